// ===== design/iem_pkg.sv =====
// ----------------------------------------------------------------------------
// iem_pkg: shared types and constants for the RGB image error metrics core
// Word layouts, accumulator widths, luminance weights and sequencer states.
// ----------------------------------------------------------------------------
package iem_pkg;

  localparam int MAX_PIXELS = 1048576;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

  localparam int SMP_W      = 24;
  localparam int DIFF_W     = 25;
  localparam int SQ_W       = 33;
  localparam int ABS_SUM_W  = 45;
  localparam int RSQ_W      = 54;
  localparam int LSQ_W      = 53;
  localparam int PROD_W     = 41;
  localparam int LUMA_W     = 43;
  localparam int LDM_W      = 25;
  localparam int LSQ_TERM_W = 34;

  localparam int DEN_W      = CNT_W + 2;
  localparam int NUM_W      = RSQ_W + 16;
  localparam int STEP_W     = $clog2(NUM_W);
  localparam int ROOT_X_W   = 57;
  localparam int ROOT_W     = 58;
  localparam int FRAC       = 20;
  localparam int LOG_W      = 25;
  localparam int PSNR_W     = 16;

  localparam logic signed [16:0] LUMA_WEIGHT [3] = '{17'sd13933, 17'sd46871, 17'sd4732};
  localparam logic [30:0]        DB_PER_OCTAVE   = 31'd1616142483;
  localparam logic [23:0]        ONE_Q16         = 24'd65536;
  localparam logic [23:0]        MASK24          = 24'hFFFFFF;
  localparam logic [NUM_W-17:0]  MS_CAP          = (NUM_W - 16)'(64'd1 << 40);
  localparam logic [PSNR_W-1:0]  PSNR_TOP        = 16'h7FFF;
  localparam logic [PSNR_W-1:0]  PSNR_BOTTOM     = 16'h8000;

  typedef struct packed {
    logic signed [SMP_W-1:0] ref_red;
    logic signed [SMP_W-1:0] ref_green;
    logic signed [SMP_W-1:0] ref_blue;
    logic signed [SMP_W-1:0] test_red;
    logic signed [SMP_W-1:0] test_green;
    logic signed [SMP_W-1:0] test_blue;
    logic                    last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [23:0]              mean_abs_red;
    logic [23:0]              mean_abs_green;
    logic [23:0]              mean_abs_blue;
    logic [23:0]              max_abs_red;
    logic [23:0]              max_abs_green;
    logic [23:0]              max_abs_blue;
    logic [23:0]              rgb_rmse;
    logic signed [PSNR_W-1:0] rgb_psnr;
    logic [23:0]              luma_rmse;
    logic signed [PSNR_W-1:0] luma_psnr;
    logic [23:0]              peak_value;
    logic [23:0]              peak_luma;
  } result_t;

  typedef struct packed {
    logic load;
    logic acc;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic [ABS_SUM_W-1:0] abs_sum;
    logic [DIFF_W-1:0]    abs_max;
    logic [RSQ_W-1:0]     sq_sum;
    logic [SMP_W-1:0]     peak;
  } lane_stat_t;

  typedef struct packed {
    logic [LSQ_W-1:0] sq_sum;
    logic [SMP_W-1:0] peak;
  } luma_stat_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_DIV_LOAD,
    F_DIV_RUN,
    F_SQRT_LOAD,
    F_SQRT_RUN,
    F_LOG_LOAD,
    F_LOG_NORM,
    F_LOG_SQR,
    F_LOG_ADJ,
    F_PSNR_MUL,
    F_PSNR_SAT,
    F_DONE
  } fin_state_t;

endpackage

// ===== design/rgb_image_error_metrics_core.sv =====
// ----------------------------------------------------------------------------
// rgb_image_error_metrics_core: RGB and luminance error metrics per frame
// Three colour lanes and a luminance merge accumulate over the frame; an
// end of frame sequencer forms means, RMSE and PSNR.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one pixel pair word (reference and test
//   RGB, signed Q8.16) plus last_pixel. out_valid/out_stall/out_data carry
//   one result word per frame, issued after the word marked last_pixel.
//   Within a frame one word is taken every cycle; the lanes run a
//   registered pipeline into the accumulators.
//   After the last word in_stall rises and stays high until the result word
//   is taken. The result is formed in turn by the serial divider (one
//   quotient bit a cycle over five divisions), the two-bit-a-cycle square
//   root, the squaring log2 unit (one fraction bit per square and adjust
//   step) and the PSNR scaling.
//   Words past the pixel limit are not accumulated but last_pixel still
//   closes the frame. While out_stall is high the result word holds.
//   Synchronous reset clears all accumulators and the sequencer.
// ----------------------------------------------------------------------------
module rgb_image_error_metrics_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  iem_pkg::pixel_t   in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output iem_pkg::result_t  out_data
);

  logic                              accept;
  logic                              v1, v2, v3, l1, l2, l3, last4;
  logic                              last_pend;
  logic                              fin_busy;
  logic                              acc_ok;
  logic [iem_pkg::CNT_W-1:0]         count;
  iem_pkg::lane_ctrl_t               ctrl;

  logic signed [iem_pkg::SMP_W-1:0]  ref_smp [3];
  logic signed [iem_pkg::SMP_W-1:0]  test_smp [3];
  logic signed [iem_pkg::PROD_W-1:0] ref_prod [3];
  logic signed [iem_pkg::PROD_W-1:0] test_prod [3];
  iem_pkg::lane_stat_t               lane_stat [3];
  iem_pkg::luma_stat_t               luma_stat;

  assign in_stall = fin_busy || last_pend;
  assign accept   = in_valid && !in_stall;
  assign acc_ok   = v3 && (count < iem_pkg::CNT_W'(iem_pkg::MAX_PIXELS));

  assign ctrl.load  = accept;
  assign ctrl.acc   = acc_ok;
  assign ctrl.clear = last4;

  assign ref_smp[0]  = in_data.ref_red;
  assign ref_smp[1]  = in_data.ref_green;
  assign ref_smp[2]  = in_data.ref_blue;
  assign test_smp[0] = in_data.test_red;
  assign test_smp[1] = in_data.test_green;
  assign test_smp[2] = in_data.test_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      l1        <= 1'b0;
      l2        <= 1'b0;
      l3        <= 1'b0;
      last4     <= 1'b0;
      last_pend <= 1'b0;
      count     <= '0;
    end else begin
      v1    <= accept;
      l1    <= accept && in_data.last_pixel;
      v2    <= v1;
      l2    <= l1;
      v3    <= v2;
      l3    <= l2;
      last4 <= v3 && l3;
      // hold off new words from the last word until the sequencer starts
      if (accept && in_data.last_pixel) begin
        last_pend <= 1'b1;
      end else if (last4) begin
        last_pend <= 1'b0;
      end
      if (last4) begin
        count <= '0;
      end else if (acc_ok) begin
        count <= count + 1'b1;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    iem_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ref_smp   (ref_smp[i]),
      .test_smp  (test_smp[i]),
      .weight    (iem_pkg::LUMA_WEIGHT[i]),
      .ctrl      (ctrl),
      .ref_prod  (ref_prod[i]),
      .test_prod (test_prod[i]),
      .stat      (lane_stat[i])
    );
  end

  iem_luma u_luma (
    .clk       (clk),
    .rst       (rst),
    .ref_prod  (ref_prod),
    .test_prod (test_prod),
    .ctrl      (ctrl),
    .stat      (luma_stat)
  );

  iem_final u_final (
    .clk       (clk),
    .rst       (rst),
    .start     (last4),
    .lanes     (lane_stat),
    .luma      (luma_stat),
    .count     (count),
    .out_stall (out_stall),
    .busy      (fin_busy),
    .out_valid (out_valid),
    .result    (out_data)
  );

endmodule

// ===== design/iem_lane.sv =====
// ----------------------------------------------------------------------------
// iem_lane: one colour channel lane
// Absolute difference, rounded square, reference magnitude and weighted
// luminance products; saturating sum, maximum and peak per channel.
// ----------------------------------------------------------------------------
module iem_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [iem_pkg::SMP_W-1:0]     ref_smp,
  input  logic signed [iem_pkg::SMP_W-1:0]     test_smp,
  input  logic signed [16:0]                   weight,
  input  iem_pkg::lane_ctrl_t                  ctrl,
  output logic signed [iem_pkg::PROD_W-1:0]    ref_prod,
  output logic signed [iem_pkg::PROD_W-1:0]    test_prod,
  output iem_pkg::lane_stat_t                  stat
);

  logic signed [iem_pkg::DIFF_W-1:0] diff;
  logic [iem_pkg::DIFF_W-1:0]        diff_mag;
  logic [iem_pkg::SMP_W-1:0]         ref_mag;

  logic [iem_pkg::DIFF_W-1:0]        ad1, ad2, ad3;
  logic [iem_pkg::SMP_W-1:0]         pa1, pa2, pa3;
  logic [iem_pkg::SQ_W-1:0]          sq2, sq3;
  logic [49:0]                       sq_full;

  logic [iem_pkg::ABS_SUM_W:0]       abs_sum_add;
  logic [iem_pkg::RSQ_W:0]           sq_sum_add;

  assign diff     = {ref_smp[23], ref_smp} - {test_smp[23], test_smp};
  assign diff_mag = diff[iem_pkg::DIFF_W-1] ? iem_pkg::DIFF_W'(-diff) : iem_pkg::DIFF_W'(diff);
  assign ref_mag  = ref_smp[23] ? iem_pkg::SMP_W'(-ref_smp) : iem_pkg::SMP_W'(ref_smp);
  assign sq_full  = {25'd0, ad1} * {25'd0, ad1} + 50'd32768;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ad1       <= diff_mag;
      pa1       <= ref_mag;
      ref_prod  <= ref_smp * weight;
      test_prod <= test_smp * weight;
    end
    sq2 <= sq_full[48:16];
    ad2 <= ad1;
    pa2 <= pa1;
    sq3 <= sq2;
    ad3 <= ad2;
    pa3 <= pa2;
  end

  assign abs_sum_add = {1'b0, stat.abs_sum} + (iem_pkg::ABS_SUM_W + 1)'(ad3);
  assign sq_sum_add  = {1'b0, stat.sq_sum} + (iem_pkg::RSQ_W + 1)'(sq3);

  // saturate on carry out: the accumulator never exceeds its all-ones limit
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      stat <= '0;
    end else if (ctrl.acc) begin
      stat.abs_sum <= abs_sum_add[iem_pkg::ABS_SUM_W] ? '1
                                                      : abs_sum_add[iem_pkg::ABS_SUM_W-1:0];
      stat.sq_sum  <= sq_sum_add[iem_pkg::RSQ_W] ? '1 : sq_sum_add[iem_pkg::RSQ_W-1:0];
      if (ad3 > stat.abs_max) begin
        stat.abs_max <= ad3;
      end
      if (pa3 > stat.peak) begin
        stat.peak <= pa3;
      end
    end
  end

endmodule

// ===== design/iem_luma.sv =====
// ----------------------------------------------------------------------------
// iem_luma: luminance merge
// Sums the weighted lane products into reference and test luminance, rounds
// the difference and reference magnitudes, squares and accumulates.
// ----------------------------------------------------------------------------
module iem_luma (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [iem_pkg::PROD_W-1:0] ref_prod [3],
  input  logic signed [iem_pkg::PROD_W-1:0] test_prod [3],
  input  iem_pkg::lane_ctrl_t               ctrl,
  output iem_pkg::luma_stat_t               stat
);

  logic signed [iem_pkg::LUMA_W-1:0] la, lb, dd;
  logic [iem_pkg::LUMA_W-1:0]        la_mag, dd_mag, la_rnd, dd_rnd;
  logic [iem_pkg::LDM_W-1:0]         ldm2;
  logic [iem_pkg::SMP_W-1:0]         lam2, lam3;
  logic [49:0]                       lsq_full;
  logic [iem_pkg::LSQ_TERM_W-1:0]    lsq3;
  logic [iem_pkg::LSQ_W:0]           sq_sum_add;

  assign la = iem_pkg::LUMA_W'(ref_prod[0]) + iem_pkg::LUMA_W'(ref_prod[1])
            + iem_pkg::LUMA_W'(ref_prod[2]);
  assign lb = iem_pkg::LUMA_W'(test_prod[0]) + iem_pkg::LUMA_W'(test_prod[1])
            + iem_pkg::LUMA_W'(test_prod[2]);
  assign dd = la - lb;

  assign la_mag = la[iem_pkg::LUMA_W-1] ? iem_pkg::LUMA_W'(-la) : iem_pkg::LUMA_W'(la);
  assign dd_mag = dd[iem_pkg::LUMA_W-1] ? iem_pkg::LUMA_W'(-dd) : iem_pkg::LUMA_W'(dd);
  assign la_rnd = la_mag + iem_pkg::LUMA_W'(32768);
  assign dd_rnd = dd_mag + iem_pkg::LUMA_W'(32768);

  assign lsq_full = {25'd0, ldm2} * {25'd0, ldm2} + 50'd32768;

  always_ff @(posedge clk) begin
    ldm2 <= dd_rnd[16 +: iem_pkg::LDM_W];
    lam2 <= la_rnd[16 +: iem_pkg::SMP_W];
    lsq3 <= lsq_full[49:16];
    lam3 <= lam2;
  end

  assign sq_sum_add = {1'b0, stat.sq_sum} + (iem_pkg::LSQ_W + 1)'(lsq3);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      stat <= '0;
    end else if (ctrl.acc) begin
      stat.sq_sum <= sq_sum_add[iem_pkg::LSQ_W] ? '1 : sq_sum_add[iem_pkg::LSQ_W-1:0];
      if (lam3 > stat.peak) begin
        stat.peak <= lam3;
      end
    end
  end

endmodule

// ===== design/iem_final.sv =====
// ----------------------------------------------------------------------------
// iem_final: end of frame sequencer
// Snapshots the merged lane results, then runs a shared serial divider,
// a digit-by-digit square root, a squaring log2 unit and the PSNR scaling.
// ----------------------------------------------------------------------------
module iem_final (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  iem_pkg::lane_stat_t         lanes [3],
  input  iem_pkg::luma_stat_t         luma,
  input  logic [iem_pkg::CNT_W-1:0]   count,
  input  logic                        out_stall,
  output logic                        busy,
  output logic                        out_valid,
  output iem_pkg::result_t            result
);

  iem_pkg::fin_state_t state, state_next;
  logic [2:0]                     job;
  logic [iem_pkg::STEP_W-1:0]     step;

  logic [iem_pkg::ABS_SUM_W-1:0]  sums [3];
  logic [23:0]                    maxv [3];
  logic [iem_pkg::RSQ_W-1:0]      rsq;
  logic [iem_pkg::LSQ_W-1:0]      lsq;
  logic [23:0]                    pk, pl;
  logic [iem_pkg::CNT_W-1:0]      n;

  logic [iem_pkg::NUM_W-1:0]      num, q_new;
  logic [iem_pkg::DEN_W-1:0]      den, rem;
  logic [iem_pkg::DEN_W:0]        div_sh;
  logic                           q_bit;

  logic [23:0]                    mean [3];
  logic [iem_pkg::ROOT_X_W-1:0]   sqx [2];
  logic [iem_pkg::ROOT_X_W-1:0]   ms_clamped;
  logic [23:0]                    rmse [2];

  logic [iem_pkg::ROOT_W-1:0]     srem, sres, sbit, s_trial, sres_new;

  logic [23:0]                    lm, log_src;
  logic [4:0]                     le;
  logic [31:0]                    ly;
  logic [63:0]                    lprod;
  logic [32:0]                    lsq_t;
  logic [iem_pkg::LOG_W-1:0]      lres, lres_new;
  logic [iem_pkg::LOG_W-1:0]      lg [4];

  logic signed [iem_pkg::LOG_W:0] ld;
  logic [iem_pkg::LOG_W-1:0]      ld_mag;
  logic [55:0]                    pprod;
  logic [56:0]                    p_rnd;
  logic [16:0]                    p_mag;
  logic                           pneg;
  logic [iem_pkg::PSNR_W-1:0]     psnr [2];
  logic [iem_pkg::PSNR_W-1:0]     psnr_val;

  logic [23:0]                    pk_max01, pk_max;

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      iem_pkg::F_IDLE:      if (start) state_next = iem_pkg::F_DIV_LOAD;
      iem_pkg::F_DIV_LOAD:  state_next = iem_pkg::F_DIV_RUN;
      iem_pkg::F_DIV_RUN: begin
        if (step == iem_pkg::STEP_W'(iem_pkg::NUM_W - 1)) begin
          state_next = (job == 3'd4) ? iem_pkg::F_SQRT_LOAD : iem_pkg::F_DIV_LOAD;
        end
      end
      iem_pkg::F_SQRT_LOAD: state_next = iem_pkg::F_SQRT_RUN;
      iem_pkg::F_SQRT_RUN: begin
        if (sbit[0]) begin
          state_next = (job == 3'd1) ? iem_pkg::F_LOG_LOAD : iem_pkg::F_SQRT_LOAD;
        end
      end
      iem_pkg::F_LOG_LOAD:  state_next = iem_pkg::F_LOG_NORM;
      iem_pkg::F_LOG_NORM:  if (lm[23]) state_next = iem_pkg::F_LOG_SQR;
      iem_pkg::F_LOG_SQR:   state_next = iem_pkg::F_LOG_ADJ;
      iem_pkg::F_LOG_ADJ: begin
        if (step == '0) begin
          state_next = (job == 3'd3) ? iem_pkg::F_PSNR_MUL : iem_pkg::F_LOG_LOAD;
        end else begin
          state_next = iem_pkg::F_LOG_SQR;
        end
      end
      iem_pkg::F_PSNR_MUL:  state_next = iem_pkg::F_PSNR_SAT;
      iem_pkg::F_PSNR_SAT: begin
        state_next = (job == 3'd1) ? iem_pkg::F_DONE : iem_pkg::F_PSNR_MUL;
      end
      iem_pkg::F_DONE:      if (!out_stall) state_next = iem_pkg::F_IDLE;
      default:              state_next = iem_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iem_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- outputs ----
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      iem_pkg::F_IDLE: busy = 1'b0;
      iem_pkg::F_DONE: out_valid = 1'b1;
      default:         busy = 1'b1;
    endcase
  end

  // ---- datapath helpers ----
  assign pk_max01 = (lanes[0].peak > lanes[1].peak) ? lanes[0].peak : lanes[1].peak;
  assign pk_max   = (pk_max01 > lanes[2].peak) ? pk_max01 : lanes[2].peak;

  assign div_sh = {rem, num[iem_pkg::NUM_W-1]};
  assign q_bit  = (div_sh >= {1'b0, den});
  assign q_new  = {num[iem_pkg::NUM_W-2:0], q_bit};

  // cap the integer part of the mean square, keep its fraction
  assign ms_clamped = (q_new[iem_pkg::NUM_W-1:16] > iem_pkg::MS_CAP)
                    ? {1'b1, 40'd0, q_new[15:0]} : q_new[iem_pkg::ROOT_X_W-1:0];

  assign s_trial  = sres + sbit;
  assign sres_new = (srem >= s_trial) ? ((sres >> 1) + sbit) : (sres >> 1);

  always_comb begin
    case (job[1:0])
      2'd0:    log_src = pk;
      2'd1:    log_src = rmse[0];
      2'd2:    log_src = pl;
      default: log_src = rmse[1];
    endcase
  end

  assign lsq_t    = lprod[63:31];
  assign lres_new = lres | (lsq_t[32] ? (iem_pkg::LOG_W'(1) << step[4:0]) : '0);

  assign ld     = $signed({1'b0, lg[{job[0], 1'b0}]}) - $signed({1'b0, lg[{job[0], 1'b1}]});
  assign ld_mag = ld[iem_pkg::LOG_W] ? iem_pkg::LOG_W'(-ld) : iem_pkg::LOG_W'(ld);
  assign p_rnd  = {1'b0, pprod} + (57'd1 << 39);
  assign p_mag  = p_rnd[56:40];

  always_comb begin
    if (rmse[job[0]] == '0) begin
      psnr_val = iem_pkg::PSNR_TOP;
    end else if (!pneg) begin
      psnr_val = (p_mag > 17'd32767) ? iem_pkg::PSNR_TOP : p_mag[15:0];
    end else begin
      psnr_val = (p_mag > 17'd32768) ? iem_pkg::PSNR_BOTTOM : 16'(-p_mag);
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    if (rst) begin
      job <= '0;
    end else begin
      unique case (state)
        iem_pkg::F_IDLE: begin
          job <= '0;
          if (start) begin
            for (int c = 0; c < 3; c++) begin
              sums[c] <= lanes[c].abs_sum;
              maxv[c] <= lanes[c].abs_max[23:0];
            end
            lsq <= luma.sq_sum;
            pk  <= (pk_max == '0) ? iem_pkg::ONE_Q16 : pk_max;
            pl  <= (luma.peak == '0) ? iem_pkg::ONE_Q16 : luma.peak;
            n   <= (count == '0) ? iem_pkg::CNT_W'(1) : count;
            begin : merge_sq
              logic [iem_pkg::RSQ_W+1:0] tot;
              tot = (iem_pkg::RSQ_W + 2)'(lanes[0].sq_sum)
                  + (iem_pkg::RSQ_W + 2)'(lanes[1].sq_sum)
                  + (iem_pkg::RSQ_W + 2)'(lanes[2].sq_sum);
              rsq <= (|tot[iem_pkg::RSQ_W+1:iem_pkg::RSQ_W]) ? '1 : tot[iem_pkg::RSQ_W-1:0];
            end
          end
        end
        iem_pkg::F_DIV_LOAD: begin
          rem  <= '0;
          step <= '0;
          case (job)
            3'd3: begin
              num <= {rsq, 16'd0};
              den <= iem_pkg::DEN_W'({n, 1'b0}) + iem_pkg::DEN_W'(n);
            end
            3'd4: begin
              num <= iem_pkg::NUM_W'({lsq, 16'd0});
              den <= iem_pkg::DEN_W'(n);
            end
            default: begin
              num <= iem_pkg::NUM_W'(sums[job[1:0]]) + iem_pkg::NUM_W'(n >> 1);
              den <= iem_pkg::DEN_W'(n);
            end
          endcase
        end
        iem_pkg::F_DIV_RUN: begin
          num  <= q_new;
          rem  <= q_bit ? iem_pkg::DEN_W'(div_sh - {1'b0, den}) : div_sh[iem_pkg::DEN_W-1:0];
          step <= step + 1'b1;
          if (step == iem_pkg::STEP_W'(iem_pkg::NUM_W - 1)) begin
            if (job == 3'd3 || job == 3'd4) begin
              sqx[job == 3'd4] <= ms_clamped;
            end else begin
              mean[job[1:0]] <= (|q_new[iem_pkg::NUM_W-1:24]) ? iem_pkg::MASK24 : q_new[23:0];
            end
            job <= (job == 3'd4) ? 3'd0 : job + 3'd1;
          end
        end
        iem_pkg::F_SQRT_LOAD: begin
          srem <= iem_pkg::ROOT_W'(sqx[job[0]]);
          sres <= '0;
          sbit <= iem_pkg::ROOT_W'(1) << 56;
        end
        iem_pkg::F_SQRT_RUN: begin
          if (srem >= s_trial) begin
            srem <= srem - s_trial;
          end
          sres <= sres_new;
          sbit <= sbit >> 2;
          if (sbit[0]) begin
            rmse[job[0]] <= (|sres_new[iem_pkg::ROOT_W-1:24]) ? iem_pkg::MASK24 : sres_new[23:0];
            job <= (job == 3'd1) ? 3'd0 : job + 3'd1;
          end
        end
        iem_pkg::F_LOG_LOAD: begin
          // a zero source only feeds an unused log: treat it as one
          lm   <= (log_src == '0) ? 24'd1 : log_src;
          le   <= 5'd23;
          step <= iem_pkg::STEP_W'(iem_pkg::FRAC - 1);
        end
        iem_pkg::F_LOG_NORM: begin
          if (lm[23]) begin
            ly   <= {lm, 8'd0};
            lres <= iem_pkg::LOG_W'({le, 20'd0});
          end else begin
            lm <= lm << 1;
            le <= le - 5'd1;
          end
        end
        iem_pkg::F_LOG_SQR: begin
          lprod <= {32'd0, ly} * {32'd0, ly};
        end
        iem_pkg::F_LOG_ADJ: begin
          ly   <= lsq_t[32] ? lsq_t[32:1] : lsq_t[31:0];
          lres <= lres_new;
          step <= step - 1'b1;
          if (step == '0) begin
            lg[job[1:0]] <= lres_new;
            job <= (job == 3'd3) ? 3'd0 : job + 3'd1;
          end
        end
        iem_pkg::F_PSNR_MUL: begin
          pprod <= {31'd0, ld_mag} * {25'd0, iem_pkg::DB_PER_OCTAVE};
          pneg  <= ld[iem_pkg::LOG_W];
        end
        iem_pkg::F_PSNR_SAT: begin
          psnr[job[0]] <= psnr_val;
          job <= (job == 3'd1) ? 3'd0 : job + 3'd1;
        end
        iem_pkg::F_DONE: begin
          job <= '0;
        end
        default: job <= '0;
      endcase
    end
  end

  assign result.mean_abs_red   = mean[0];
  assign result.mean_abs_green = mean[1];
  assign result.mean_abs_blue  = mean[2];
  assign result.max_abs_red    = maxv[0];
  assign result.max_abs_green  = maxv[1];
  assign result.max_abs_blue   = maxv[2];
  assign result.rgb_rmse       = rmse[0];
  assign result.rgb_psnr       = psnr[0];
  assign result.luma_rmse      = rmse[1];
  assign result.luma_psnr      = psnr[1];
  assign result.peak_value     = pk;
  assign result.peak_luma      = pl;

endmodule
